@@ sv/assert_macros.svh @@
// Assertion macros used by the port checker module.
// Needs clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every rising clock edge outside reset
`define FCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fct_pkg.sv @@
// Shared constants and types for the conductivity tensor block.
// No dependencies.
`timescale 1ns / 1ps
package fct_pkg;

  localparam int NUM_DIM      = 3;
  localparam int NUM_ENT      = 6;
  localparam int REGION_COUNT = 64;
  localparam int COMP_W       = 16;
  localparam int MAG_W        = 15;
  localparam int STEPS        = 15;
  localparam int NRM_W        = 68;
  localparam int SIGMA_W      = 24;
  localparam int SCALE_W      = 16;
  localparam int EFF_W        = 28;
  localparam int PP_W         = 30;
  localparam int TERM_W       = 59;
  localparam int OUT_W        = 32;

  localparam logic [MAG_W-1:0]   UNIT_Q14  = 15'd16384;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;

  // normaliser first; then products, sigma products, sum
  localparam int NRM_LAT   = STEPS + 3;
  localparam int LAT       = NRM_LAT + 3;
  localparam int EFF_FIRST = 2;
  localparam int EFF_LAST  = NRM_LAT;

  typedef enum logic [2:0] {
    CFG_SIGMA_FIBER   = 3'd0,
    CFG_SIGMA_SHEET   = 3'd1,
    CFG_SIGMA_NORMAL  = 3'd2,
    CFG_FIB_SCALE     = 3'd3,
    CFG_AV_SCALE      = 3'd4,
    CFG_FIB_MASK      = 3'd5,
    CFG_AV_MASK       = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SC_NONE     = 2'd0,
    SC_FIBROSIS = 2'd1,
    SC_AV_DELAY = 2'd2
  } scale_code_e;

  // row and column of the six distinct tensor entries
  localparam logic [1:0] PAIR_I [NUM_ENT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [NUM_ENT] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

endpackage

@@ sv/fct_norm.sv @@
// Pipelined normaliser for one 3D vector: Q2.13 in, rounded Q1.14 unit out.
// One result bit per stage, squares tracked by shift and add. Uses fct_pkg.
`timescale 1ns / 1ps
module fct_norm (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [1:0]                          axis_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   c_i [fct_pkg::NUM_DIM],
  output logic signed [fct_pkg::COMP_W-1:0]   u_o [fct_pkg::NUM_DIM]
);
  import fct_pkg::*;

  logic [2*COMP_W-2:0] sq_q  [NUM_DIM];
  logic                neg0_q [NUM_DIM];

  logic [2*COMP_W-1:0] s_q   [0:STEPS];
  logic                zero_q [0:STEPS];
  logic [2*COMP_W-2:0] c2_q  [0:STEPS][NUM_DIM];
  logic                neg_q [0:STEPS][NUM_DIM];
  logic [MAG_W-1:0]    m_q   [0:STEPS][NUM_DIM];
  logic [NRM_W-1:0]    a_q   [0:STEPS][NUM_DIM];
  logic [NRM_W-1:0]    b_q   [0:STEPS][NUM_DIM];

  logic signed [2*COMP_W-1:0] prod [NUM_DIM];
  logic [2*COMP_W-1:0]        sum_d;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_DIM; i++) begin
      prod[i] = c_i[i] * c_i[i];
      sum_d   = sum_d + (2*COMP_W)'(sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_DIM; i++) begin
        sq_q[i]   <= prod[i][2*COMP_W-2:0];
        neg0_q[i] <= c_i[i][COMP_W-1];
      end
      s_q[0]    <= sum_d;
      zero_q[0] <= (sum_d == '0);
      for (int i = 0; i < NUM_DIM; i++) begin
        c2_q[0][i]  <= sq_q[i];
        neg_q[0][i] <= neg0_q[i];
        m_q[0][i]   <= '0;
        a_q[0][i]   <= '0;
        b_q[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = STEPS - 1 - k;
    logic [NRM_W-1:0] s_w;
    assign s_w = NRM_W'(s_q[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1]    <= s_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end

    for (genvar i = 0; i < NUM_DIM; i++) begin : g_lane
      logic [NRM_W-1:0] trial;
      logic [NRM_W-1:0] rhs;
      logic             take;

      // (2t-1)^2 * S from the running (2m)^2 * S and 2m * S
      assign trial = a_q[k][i] + (b_q[k][i] << (BIT + 2)) - (b_q[k][i] << 1)
                   + (s_w << (2*BIT + 2)) - (s_w << (BIT + 2)) + s_w;
      assign rhs   = NRM_W'(c2_q[k][i]) << 30;
      assign take  = !m_q[k][i][MAG_W-1] && (trial <= rhs);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          c2_q[k+1][i]  <= c2_q[k][i];
          neg_q[k+1][i] <= neg_q[k][i];
          if (take) begin
            m_q[k+1][i] <= m_q[k][i] | (MAG_W'(1) << BIT);
            a_q[k+1][i] <= a_q[k][i] + (b_q[k][i] << (BIT + 2)) + (s_w << (2*BIT + 2));
            b_q[k+1][i] <= b_q[k][i] + (s_w << (BIT + 1));
          end else begin
            m_q[k+1][i] <= m_q[k][i];
            a_q[k+1][i] <= a_q[k][i];
            b_q[k+1][i] <= b_q[k][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_DIM; i++) begin
        if (zero_q[STEPS]) begin
          u_o[i] <= (2'(i) == axis_i) ? COMP_W'(UNIT_Q14) : '0;
        end else if (neg_q[STEPS][i]) begin
          u_o[i] <= -$signed(COMP_W'(m_q[STEPS][i]));
        end else begin
          u_o[i] <= $signed(COMP_W'(m_q[STEPS][i]));
        end
      end
    end
  end

endmodule

@@ sv/fiber_conductivity_tensor.sv @@
// Top level: orthotropic conductivity tensor, one quadrature point per word.
// Uses fct_pkg and fct_norm.
//
//   channel | handshake                | payload
//   in      | in_valid_i / in_ready_o  | fiber/sheet/normal x,y,z, region
//   out     | out_valid_o / out_ready_i| k_xx..k_zz, scale_used
//   cfg     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while output words are taken; the pipe is the
// 15-stage bit-per-stage normaliser followed by the product and rounding stages.
// Whole pipe advances together; it holds when the output word is not taken.
// Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
module fiber_conductivity_tensor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [63:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fct_pkg::COMP_W-1:0]   fiber_x_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   fiber_y_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   fiber_z_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   sheet_x_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   sheet_y_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   sheet_z_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   normal_x_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   normal_y_i,
  input  logic signed [fct_pkg::COMP_W-1:0]   normal_z_i,
  input  logic [5:0]                          region_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fct_pkg::OUT_W-1:0]    k_xx_o,
  output logic signed [fct_pkg::OUT_W-1:0]    k_xy_o,
  output logic signed [fct_pkg::OUT_W-1:0]    k_xz_o,
  output logic signed [fct_pkg::OUT_W-1:0]    k_yy_o,
  output logic signed [fct_pkg::OUT_W-1:0]    k_yz_o,
  output logic signed [fct_pkg::OUT_W-1:0]    k_zz_o,
  output logic [1:0]                          scale_used_o
);
  import fct_pkg::*;

  logic [SIGMA_W-1:0] sigma_q [NUM_DIM];
  logic [SCALE_W-1:0] fib_scale_q, av_scale_q;
  logic [63:0]        fib_mask_q, av_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIM; i++) sigma_q[i] <= '0;
      fib_scale_q <= SCALE_ONE;
      av_scale_q  <= SCALE_ONE;
      fib_mask_q  <= '0;
      av_mask_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SIGMA_FIBER:  sigma_q[0]  <= cfg_data_i[SIGMA_W-1:0];
        CFG_SIGMA_SHEET:  sigma_q[1]  <= cfg_data_i[SIGMA_W-1:0];
        CFG_SIGMA_NORMAL: sigma_q[2]  <= cfg_data_i[SIGMA_W-1:0];
        CFG_FIB_SCALE:    fib_scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_AV_SCALE:     av_scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_FIB_MASK:     fib_mask_q  <= cfg_data_i;
        CFG_AV_MASK:      av_mask_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // normalisers
  logic signed [COMP_W-1:0] c_w [NUM_DIM][NUM_DIM];
  logic signed [COMP_W-1:0] u_w [NUM_DIM][NUM_DIM];

  assign c_w[0][0] = fiber_x_i;
  assign c_w[0][1] = fiber_y_i;
  assign c_w[0][2] = fiber_z_i;
  assign c_w[1][0] = sheet_x_i;
  assign c_w[1][1] = sheet_y_i;
  assign c_w[1][2] = sheet_z_i;
  assign c_w[2][0] = normal_x_i;
  assign c_w[2][1] = normal_y_i;
  assign c_w[2][2] = normal_z_i;

  for (genvar v = 0; v < NUM_DIM; v++) begin : g_norm
    fct_norm u_norm (
      .clk_i  (clk_i),
      .en_i   (en),
      .axis_i (2'(v)),
      .c_i    (c_w[v]),
      .u_o    (u_w[v])
    );
  end

  // region scale and effective sigmas
  scale_code_e        code_d;
  logic [SCALE_W-1:0] scale_d;
  scale_code_e        code_q [LAT];
  logic [SCALE_W-1:0] scale_q;
  logic [SIGMA_W+SCALE_W-1:0] sprod_q [NUM_DIM];
  logic [EFF_W-1:0]   eff_q [EFF_FIRST:EFF_LAST][NUM_DIM];

  always_comb begin
    code_d  = SC_NONE;
    scale_d = SCALE_ONE;
    if (region_i != '0 && {1'b0, region_i} < 7'(REGION_COUNT)) begin
      priority if (fib_mask_q[region_i]) begin
        code_d  = SC_FIBROSIS;
        scale_d = fib_scale_q;
      end else if (av_mask_q[region_i]) begin
        code_d  = SC_AV_DELAY;
        scale_d = av_scale_q;
      end else begin
        code_d  = SC_NONE;
        scale_d = SCALE_ONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      code_q[0] <= code_d;
      scale_q   <= scale_d;
      for (int k = 1; k < LAT; k++) code_q[k] <= code_q[k-1];
      for (int i = 0; i < NUM_DIM; i++) begin
        sprod_q[i]          <= sigma_q[i] * scale_q;
        eff_q[EFF_FIRST][i] <= EFF_W'(({1'b0, sprod_q[i]} + 41'd2048) >> 12);
        for (int k = EFF_FIRST + 1; k <= EFF_LAST; k++) eff_q[k][i] <= eff_q[k-1][i];
      end
    end
  end

  // direction products, sigma products, sum, round and saturate
  logic signed [PP_W-1:0]   pp_q   [NUM_DIM][NUM_ENT];
  logic signed [TERM_W-1:0] term_q [NUM_DIM][NUM_ENT];
  logic signed [OUT_W-1:0]  k_q    [NUM_ENT];
  logic signed [2*COMP_W-1:0] pp_full [NUM_DIM][NUM_ENT];
  logic signed [OUT_W-1:0]  k_d    [NUM_ENT];
  logic signed [TERM_W+1:0] acc    [NUM_ENT];
  logic signed [TERM_W-22:0] rnd   [NUM_ENT];

  always_comb begin
    for (int v = 0; v < NUM_DIM; v++) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        pp_full[v][e] = u_w[v][PAIR_I[e]] * u_w[v][PAIR_J[e]];
      end
    end
    for (int e = 0; e < NUM_ENT; e++) begin
      acc[e] = (TERM_W+2)'(term_q[0][e]) + (TERM_W+2)'(term_q[1][e])
             + (TERM_W+2)'(term_q[2][e]) + (TERM_W+2)'(25'sd8388608);
      rnd[e] = (TERM_W-21)'($signed(acc[e][TERM_W+1:24]));
      if (rnd[e] > (TERM_W-21)'(32'sh7fffffff)) begin
        k_d[e] = 32'sh7fffffff;
      end else if (rnd[e] < -(TERM_W-21)'(33'sh080000000)) begin
        k_d[e] = 32'sh80000000;
      end else begin
        k_d[e] = rnd[e][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < NUM_DIM; v++) begin
        for (int e = 0; e < NUM_ENT; e++) begin
          pp_q[v][e]   <= pp_full[v][e][PP_W-1:0];
          term_q[v][e] <= $signed({1'b0, eff_q[EFF_LAST][v]}) * pp_q[v][e];
        end
      end
      for (int e = 0; e < NUM_ENT; e++) k_q[e] <= k_d[e];
    end
  end

  assign k_xx_o       = k_q[0];
  assign k_xy_o       = k_q[1];
  assign k_xz_o       = k_q[2];
  assign k_yy_o       = k_q[3];
  assign k_yz_o       = k_q[4];
  assign k_zz_o       = k_q[5];
  assign scale_used_o = code_q[LAT-1];

endmodule

@@ sv/fct_checker.sv @@
// Port-level checks for the conductivity tensor block, bound to the top level.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fct_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] k_xx_o,
  input logic [1:0]  scale_used_o
);

  `FCT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(k_xx_o), "output word dropped or changed while stalled")
  `FCT_ASSERT(a_code_legal, !out_valid_o || scale_used_o != 2'd3, "illegal scale code")
  `FCT_ASSERT(a_ready_empty, out_valid_o || in_ready_o, "input held back with empty output")
  `FCT_ASSERT(a_ready_stall, !(out_valid_o && !out_ready_i) || !in_ready_o, "input taken while output stalled")

endmodule

bind fiber_conductivity_tensor fct_port_checks u_fct_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .k_xx_o       (k_xx_o),
  .scale_used_o (scale_used_o)
);

@@ tb/sv/fct_checker.sv @@
// Checker for the conductivity tensor block: tracks the registers, predicts
// each output word from the accepted input words and compares. Uses fct_pkg.
`timescale 1ns / 1ps
module fct_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic signed [15:0] fiber_x_i,
  input  logic signed [15:0] fiber_y_i,
  input  logic signed [15:0] fiber_z_i,
  input  logic signed [15:0] sheet_x_i,
  input  logic signed [15:0] sheet_y_i,
  input  logic signed [15:0] sheet_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [5:0]        region_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic signed [31:0] k_xx_i,
  input  logic signed [31:0] k_xy_i,
  input  logic signed [31:0] k_xz_i,
  input  logic signed [31:0] k_yy_i,
  input  logic signed [31:0] k_yz_i,
  input  logic signed [31:0] k_zz_i,
  input  logic [1:0]        scale_used_i,
  output int                fail_count_o,
  output int                pending_o
);
  import fct_pkg::*;

  typedef struct {
    logic signed [31:0] k [6];
    scale_code_e        code;
  } tensor_t;

  logic [23:0] sig_f, sig_s, sig_n;
  logic [15:0] fib_scale, av_scale;
  logic [63:0] fib_mask, av_mask;
  tensor_t     tensor_q [$];

  function automatic longint unit_mag(longint unsigned c2, longint unsigned s2);
    longint unsigned rhs, d, m, t;
    rhs = c2 << 30;
    m = 0;
    for (int b = 14; b >= 0; b--) begin
      t = m | (64'd1 << b);
      if (t <= 16384) begin
        d = 2 * t - 1;
        if (d * d * s2 <= rhs) m = t;
      end
    end
    return longint'(m);
  endfunction

  function automatic void unit_vec(input logic signed [15:0] c [3], input int axis,
                                   output longint u [3]);
    longint unsigned s2;
    longint v;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      v = c[i];
      s2 += longint'(v * v);
    end
    for (int i = 0; i < 3; i++) begin
      v = c[i];
      if (s2 == 0) u[i] = (i == axis) ? 16384 : 0;
      else if (v < 0) u[i] = -unit_mag(v * v, s2);
      else u[i] = unit_mag(v * v, s2);
    end
  endfunction

  function automatic tensor_t predict_tensor(input logic signed [15:0] fv [3],
      input logic signed [15:0] sv [3], input logic signed [15:0] nv [3],
      input logic [5:0] reg_no);
    tensor_t r;
    longint f [3], s [3], n [3];
    longint unsigned scale;
    longint ef, es, en, acc, rnd;
    int e;
    unit_vec(fv, 0, f);
    unit_vec(sv, 1, s);
    unit_vec(nv, 2, n);
    scale = 4096;
    r.code = SC_NONE;
    if (reg_no != 0) begin
      if (fib_mask[reg_no]) begin
        scale = fib_scale;
        r.code = SC_FIBROSIS;
      end else if (av_mask[reg_no]) begin
        scale = av_scale;
        r.code = SC_AV_DELAY;
      end
    end
    ef = longint'((sig_f * scale + 2048) >> 12);
    es = longint'((sig_s * scale + 2048) >> 12);
    en = longint'((sig_n * scale + 2048) >> 12);
    e = 0;
    for (int i = 0; i < 3; i++)
      for (int j = i; j < 3; j++) begin
        acc = ef * (f[i] * f[j]) + es * (s[i] * s[j]) + en * (n[i] * n[j]);
        rnd = (acc + (64'sd1 <<< 23)) >>> 24;
        if (rnd > 64'sd2147483647) rnd = 64'sd2147483647;
        if (rnd < -64'sd2147483648) rnd = -64'sd2147483648;
        r.k[e] = rnd[31:0];
        e++;
      end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] fv [3], sv [3], nv [3];
    logic signed [31:0] got [6];
    tensor_t want;
    int errs;
    if (!rst_ni) begin
      sig_f <= '0; sig_s <= '0; sig_n <= '0;
      fib_scale <= SCALE_ONE; av_scale <= SCALE_ONE;
      fib_mask <= '0; av_mask <= '0;
      fail_count_o <= 0;
      pending_o <= 0;
      tensor_q.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIGMA_FIBER:  sig_f <= cfg_data_i[23:0];
          CFG_SIGMA_SHEET:  sig_s <= cfg_data_i[23:0];
          CFG_SIGMA_NORMAL: sig_n <= cfg_data_i[23:0];
          CFG_FIB_SCALE:    fib_scale <= cfg_data_i[15:0];
          CFG_AV_SCALE:     av_scale <= cfg_data_i[15:0];
          CFG_FIB_MASK:     fib_mask <= cfg_data_i;
          CFG_AV_MASK:      av_mask <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        fv = '{fiber_x_i, fiber_y_i, fiber_z_i};
        sv = '{sheet_x_i, sheet_y_i, sheet_z_i};
        nv = '{normal_x_i, normal_y_i, normal_z_i};
        tensor_q.push_back(predict_tensor(fv, sv, nv, region_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (tensor_q.size() == 0) begin
          $display("%0t: output word with nothing expected", $time);
          errs++;
        end else begin
          want = tensor_q.pop_front();
          got = '{k_xx_i, k_xy_i, k_xz_i, k_yy_i, k_yz_i, k_zz_i};
          for (int e = 0; e < 6; e++)
            if (got[e] !== want.k[e]) begin
              $display("%0t: entry %0d expected %0d actual %0d", $time, e, want.k[e], got[e]);
              errs++;
            end
          if (scale_used_i !== want.code) begin
            $display("%0t: scale_used expected %0d actual %0d", $time, want.code,
                     scale_used_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= tensor_q.size();
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: drives the conductivity tensor block through several register
// settings with directed and random words. Uses fct_pkg and fct_checker.
`timescale 1ns / 1ps
module testbench;
  import fct_pkg::*;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] fx = '0, fy = '0, fz = '0, sx = '0, sy = '0, sz = '0;
  logic signed [15:0] nx = '0, ny = '0, nz = '0;
  logic [5:0] region_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] k_xx, k_xy, k_xz, k_yy, k_yz, k_zz;
  logic [1:0] scale_used;
  int fail_count, pending, cycles;
  bit quiet = 1'b0;

  always #6 clk_i = ~clk_i;

  fiber_conductivity_tensor dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .fiber_x_i(fx), .fiber_y_i(fy), .fiber_z_i(fz),
    .sheet_x_i(sx), .sheet_y_i(sy), .sheet_z_i(sz),
    .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz), .region_i,
    .out_valid_o, .out_ready_i,
    .k_xx_o(k_xx), .k_xy_o(k_xy), .k_xz_o(k_xz), .k_yy_o(k_yy), .k_yz_o(k_yz),
    .k_zz_o(k_zz), .scale_used_o(scale_used)
  );

  fct_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .fiber_x_i(fx), .fiber_y_i(fy), .fiber_z_i(fz),
    .sheet_x_i(sx), .sheet_y_i(sy), .sheet_z_i(sz),
    .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz), .region_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .k_xx_i(k_xx), .k_xy_i(k_xy), .k_xz_i(k_xz), .k_yy_i(k_yy), .k_yz_i(k_yz),
    .k_zz_i(k_zz), .scale_used_i(scale_used),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_word(input logic signed [15:0] c [9], input logic [5:0] r);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    {fx, fy, fz} <= {c[0], c[1], c[2]};
    {sx, sy, sz} <= {c[3], c[4], c[5]};
    {nx, ny, nz} <= {c[6], c[7], c[8]};
    region_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input logic [23:0] f, s, n, input logic [15:0] fs, as,
                         input logic [63:0] fm, am);
    drain();
    write_reg(CFG_SIGMA_FIBER, 64'(f));
    write_reg(CFG_SIGMA_SHEET, 64'(s));
    write_reg(CFG_SIGMA_NORMAL, 64'(n));
    write_reg(CFG_FIB_SCALE, 64'(fs));
    write_reg(CFG_AV_SCALE, 64'(as));
    write_reg(CFG_FIB_MASK, fm);
    write_reg(CFG_AV_MASK, am);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_words(input int count);
    logic signed [15:0] c [9];
    for (int i = 0; i < count; i++) begin
      foreach (c[j]) c[j] = rand_comp();
      if ($urandom_range(0, 7) == 0) {c[0], c[1], c[2]} = '0;
      if ($urandom_range(0, 7) == 0) {c[3], c[4], c[5]} = '0;
      if ($urandom_range(0, 7) == 0) {c[6], c[7], c[8]} = '0;
      send_word(c, 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    logic signed [15:0] c [9];
    cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: all sigmas zero
    random_words(20);

    set_all(24'h100000, 24'h080000, 24'h040000, 16'h2000, 16'h0800,
            64'hAAAA_0000_0000_000F, 64'h5555_0000_0000_00FC);
    // directed: zero vectors, extremes, region cases
    c = '{default: 16'sd0};
    send_word(c, 6'd0);
    send_word(c, 6'd1);
    send_word(c, 6'd2);
    send_word(c, 6'd4);
    send_word(c, 6'd63);
    c = '{default: 16'sh7fff};
    send_word(c, 6'd3);
    c = '{default: 16'sh8000};
    send_word(c, 6'd62);
    c = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sd0, 16'sh8000};
    send_word(c, 6'd61);
    c = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    send_word(c, 6'd0);
    c = '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd1};
    send_word(c, 6'd5);
    c = '{16'sd3, 16'sd4, 16'sd0, -16'sd5, 16'sd12, 16'sd0, 16'sd1, 16'sd2, 16'sd2};
    send_word(c, 6'd8);
    random_words(100);

    set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    random_words(100);

    set_all(24'hFFFFFF, 24'h000001, 24'h800000, 16'h0000, 16'h0001,
            64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    random_words(100);

    set_all(24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
            16'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    random_words(80);

    quiet = 1'b1;
    random_words(80);

    drain();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/fct_pkg.sv
sv/fct_norm.sv
sv/fiber_conductivity_tensor.sv
sv/fct_checker.sv
tb/sv/fct_checker.sv
tb/sv/testbench.sv
